@@ sv/infix_to_postfix_converter_core_macros.svh @@
// ---------------------------------------------------------------------------
// infix_to_postfix_converter_core assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// same-cycle implication
`define ITP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itp assertion failed");

// next-cycle implication
`define ITP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itp assertion failed");

`endif

@@ sv/itp_pkg.sv @@
// ---------------------------------------------------------------------------
// itp_pkg
// types, character codes and classification functions of the converter
// ---------------------------------------------------------------------------
package itp_pkg;

    typedef logic [7:0]        char_t;
    typedef logic signed [2:0] prec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPER,
        S_READ,
        S_FLUSH,
        S_FREAD
    } state_t;

    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_MUL   = 8'h2A;
    localparam char_t CH_DIV   = 8'h2F;
    localparam char_t CH_POW   = 8'h5E;
    localparam char_t CH_OPEN  = 8'h28;
    localparam char_t CH_CLOSE = 8'h29;
    localparam char_t CH_NUL   = 8'h00;

    function automatic prec_t prec_of(input char_t c);
        prec_t p;
        case (c)
            CH_PLUS, CH_MINUS: p = 3'sd1;
            CH_MUL, CH_DIV:    p = 3'sd2;
            CH_POW:            p = 3'sd3;
            default:           p = -3'sd1;
        endcase
        return p;
    endfunction

    function automatic logic is_operand(input char_t c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]};
    endfunction

endpackage

@@ sv/itp_ram.sv @@
// ---------------------------------------------------------------------------
// itp_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/infix_to_postfix_converter_core.sv @@
// ---------------------------------------------------------------------------
// infix_to_postfix_converter_core
// shunting-yard converter: infix characters in, postfix characters out,
// operator stack held in a synchronous ram
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------
//   input   | in_valid/in_stall  | symbol, final_char
//   output  | out_valid/out_stall| out_symbol, end_of_run, overflow
//
// an operand, a '(', or a ')' or operator on an empty stack needs no stack read;
// otherwise the stack top is read, each popped entry is emitted in turn and a
// closing step follows, left out when the pops empty the stack (registered ram read)
// end of expression: the flush pops every stack entry, then emits the terminator
// output stalls hold the sequencer at the pending emit
// reset empties the stack count and clears the overflow flag; no ram pass
// ---------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] symbol,
    input  logic       final_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_symbol,
    output logic       end_of_run,
    output logic       overflow
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    itp_pkg::state_t state_reg, state_next;
    itp_pkg::char_t  sym_reg, sym_next;
    logic            last_reg, last_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;

    itp_pkg::char_t  out_sym_reg;
    logic            out_end_reg;
    logic            out_ovf_reg;
    logic            out_valid_reg;

    logic            out_free;
    logic            emit;
    itp_pkg::char_t  emit_sym;
    logic            emit_end;

    logic            we;
    logic [AW-1:0]   waddr;
    logic            re;
    logic [AW-1:0]   raddr;
    itp_pkg::char_t  rdata;

    itp_pkg::char_t  cur_sym;
    logic            cur_last;
    itp_pkg::state_t done_state;
    logic            is_close;
    logic            stop;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   cnt_m2;

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (cur_sym),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itp_pkg::S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg  <= sym_next;
        last_reg <= last_next;
        if (emit)
        begin
            out_sym_reg <= emit_sym;
            out_end_reg <= emit_end;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_m1   = cnt_reg - ONE_C;
    assign cnt_m2   = cnt_reg - TWO_C;
    assign cur_sym  = (state_reg == itp_pkg::S_IDLE) ? symbol : sym_reg;
    assign cur_last = (state_reg == itp_pkg::S_IDLE) ? final_char : last_reg;
    assign done_state = cur_last ? itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
    assign is_close = (sym_reg == itp_pkg::CH_CLOSE);
    assign stop = is_close ? (rdata == itp_pkg::CH_OPEN)
                           : (itp_pkg::prec_of(sym_reg) > itp_pkg::prec_of(rdata));

    always_comb
    begin
        state_next = state_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        emit       = 1'b0;
        emit_sym   = rdata;
        emit_end   = 1'b0;
        we         = 1'b0;
        waddr      = cnt_reg[AW-1:0];
        re         = 1'b0;
        raddr      = cnt_m1[AW-1:0];
        in_stall   = (state_reg != itp_pkg::S_IDLE);

        case (state_reg)
            itp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    sym_next  = symbol;
                    last_next = final_char;
                    if (itp_pkg::is_operand(symbol))
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_sym   = symbol;
                            state_next = done_state;
                        end
                        else
                        begin
                            state_next = itp_pkg::S_OPER;
                        end
                    end
                    else if (symbol != itp_pkg::CH_OPEN && cnt_reg != '0)
                    begin
                        re         = 1'b1;
                        state_next = itp_pkg::S_READ;
                    end
                    else
                    begin
                        if (symbol != itp_pkg::CH_CLOSE)
                        begin
                            if (cnt_reg < DEPTH_C)
                            begin
                                we       = 1'b1;
                                cnt_next = cnt_reg + ONE_C;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        state_next = done_state;
                    end
                end
            end

            itp_pkg::S_OPER:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_sym   = sym_reg;
                    state_next = done_state;
                end
            end

            itp_pkg::S_READ:
            begin
                if (stop)
                begin
                    if (is_close)
                    begin
                        cnt_next = cnt_m1;
                    end
                    else if (cnt_reg < DEPTH_C)
                    begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + ONE_C;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = done_state;
                end
                else if (out_free)
                begin
                    emit     = 1'b1;
                    cnt_next = cnt_m1;
                    if (cnt_reg > ONE_C)
                    begin
                        re    = 1'b1;
                        raddr = cnt_m2[AW-1:0];
                    end
                    else
                    begin
                        if (!is_close)
                        begin
                            we       = 1'b1;
                            waddr    = '0;
                            cnt_next = cnt_reg;
                        end
                        state_next = done_state;
                    end
                end
            end

            itp_pkg::S_FLUSH:
            begin
                if (cnt_reg != '0)
                begin
                    re         = 1'b1;
                    state_next = itp_pkg::S_FREAD;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_sym   = itp_pkg::CH_NUL;
                    emit_end   = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = itp_pkg::S_IDLE;
                end
            end

            itp_pkg::S_FREAD:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    cnt_next = cnt_m1;
                    if (cnt_reg > ONE_C)
                    begin
                        re    = 1'b1;
                        raddr = cnt_m2[AW-1:0];
                    end
                    else
                    begin
                        state_next = itp_pkg::S_FLUSH;
                    end
                end
            end

            default:
            begin
                state_next = itp_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_sym_reg;
    assign end_of_run = out_end_reg;
    assign overflow   = out_ovf_reg;

endmodule

@@ sv/itp_checker.sv @@
// ---------------------------------------------------------------------------
// itp_checker
// port-level checks of the converter output channel, bound to the top level
// ---------------------------------------------------------------------------
`include "infix_to_postfix_converter_core_macros.svh"

module itp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_symbol,
    input logic       end_of_run,
    input logic       overflow
);

    // stalled transaction stays offered
    `ITP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // terminator carries a zero character
    `ITP_ASSERT_NOW(a_term_zero, out_valid && end_of_run, out_symbol == itp_pkg::CH_NUL)

    // overflow flag stays set until the terminator of the expression
    `ITP_ASSERT_NEXT(a_ovf_sticky, out_valid && !out_stall && !end_of_run && overflow, !out_valid || overflow)

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (.*);

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: infix_to_postfix_converter_core regression
// drives infix characters into the converter and checks every postfix
// transaction against a shunting-yard predictor kept in the bench; covers
// directed corner expressions, random well-formed expressions, byte noise,
// deep nesting past the stack depth, long output hold-off and idle-free runs
// ---------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 32;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 2 * STACK_DEPTH + 8;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        itp_pkg::char_t sym;
        logic           eor;
        logic           ovf;
    } postfix_t;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [7:0] symbol     = 8'h00;
    logic       final_char = 1'b0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [7:0] out_symbol;
    logic       end_of_run;
    logic       overflow;

    itp_pkg::char_t held_ops [STACK_DEPTH];
    int             held_count = 0;
    logic           drop_flag  = 1'b0;
    postfix_t       pending_postfix [$];

    bit quiet     = 1'b0;
    int hold_left = 0;

    int mismatches     = 0;
    int chars_accepted = 0;
    int results_seen   = 0;
    int flagged_seen   = 0;
    int runs_ended     = 0;

    infix_to_postfix_converter_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .symbol     (symbol),
        .final_char (final_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_symbol (out_symbol),
        .end_of_run (end_of_run),
        .overflow   (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int op_rank(input itp_pkg::char_t c);
        int r;
        case (c)
            itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: r = 1;
            itp_pkg::CH_MUL, itp_pkg::CH_DIV:    r = 2;
            itp_pkg::CH_POW:                     r = 3;
            default:                             r = -1;
        endcase
        return r;
    endfunction

    function automatic bit is_term(input itp_pkg::char_t c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic void emit_postfix(input itp_pkg::char_t c, input logic eor);
        postfix_t r;
        r.sym = c;
        r.eor = eor;
        r.ovf = drop_flag;
        pending_postfix.push_back(r);
    endfunction

    function automatic void pop_to_output();
        held_count--;
        emit_postfix(held_ops[held_count], 1'b0);
    endfunction

    function automatic void push_held(input itp_pkg::char_t c);
        if (held_count < STACK_DEPTH)
        begin
            held_ops[held_count] = c;
            held_count++;
        end
        else
            drop_flag = 1'b1;
    endfunction

    function automatic void convert_char(input itp_pkg::char_t c, input logic last);
        int rank;
        rank = op_rank(c);
        if (is_term(c))
            emit_postfix(c, 1'b0);
        else if (c == itp_pkg::CH_OPEN)
            push_held(c);
        else if (c == itp_pkg::CH_CLOSE)
        begin
            while (held_count > 0 && held_ops[held_count - 1] != itp_pkg::CH_OPEN)
                pop_to_output();
            if (held_count > 0)
                held_count--;
        end
        else
        begin
            while (held_count > 0 && rank <= op_rank(held_ops[held_count - 1]))
                pop_to_output();
            push_held(c);
        end
        if (last)
        begin
            while (held_count > 0)
                pop_to_output();
            emit_postfix(itp_pkg::CH_NUL, 1'b1);
            drop_flag = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // input transactions feed the predictor, output transactions are checked
    always @(posedge clk)
    begin
        postfix_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                convert_char(symbol, final_char);
                chars_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (overflow)
                    flagged_seen++;
                if (end_of_run)
                    runs_ended++;
                if (pending_postfix.size() == 0)
                    report_mismatch($sformatf("unexpected transaction sym=%h", out_symbol));
                else
                begin
                    want = pending_postfix.pop_front();
                    if (out_symbol !== want.sym)
                        report_mismatch($sformatf("out_symbol %h, want %h",
                                                  out_symbol, want.sym));
                    if (end_of_run !== want.eor)
                        report_mismatch($sformatf("end_of_run %b, want %b (sym %h)",
                                                  end_of_run, want.eor, want.sym));
                    if (overflow !== want.ovf)
                        report_mismatch($sformatf("overflow %b, want %b (sym %h)",
                                                  overflow, want.ovf, want.sym));
                end
            end
        end
    end

    // receiver: random stalls, idle-free stretches and long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 22);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_postfix.size());
        $display("infix_to_postfix_converter_core regression: fail");
        $finish;
    end

    task automatic send_char(input itp_pkg::char_t c, input logic last);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(99) < 22)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        symbol     <= c;
        final_char <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_postfix.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic itp_pkg::char_t random_operand();
        itp_pkg::char_t c;
        case ($urandom_range(2))
            0:       c = 8'h61 + 8'($urandom_range(25));
            1:       c = 8'h41 + 8'($urandom_range(25));
            default: c = 8'h30 + 8'($urandom_range(9));
        endcase
        return c;
    endfunction

    function automatic itp_pkg::char_t random_operator();
        itp_pkg::char_t c;
        case ($urandom_range(4))
            0:       c = itp_pkg::CH_PLUS;
            1:       c = itp_pkg::CH_MINUS;
            2:       c = itp_pkg::CH_MUL;
            3:       c = itp_pkg::CH_DIV;
            default: c = itp_pkg::CH_POW;
        endcase
        return c;
    endfunction

    task automatic send_text(input itp_pkg::char_t text [$]);
        foreach (text[i])
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic send_expression(input int terms);
        itp_pkg::char_t text [$];
        int             depth;
        depth = 0;
        for (int k = 0; k < terms; k++)
        begin
            while ($urandom_range(99) < 25)
            begin
                text.push_back(itp_pkg::CH_OPEN);
                depth++;
            end
            text.push_back(random_operand());
            while (depth > 0 && $urandom_range(99) < 35)
            begin
                text.push_back(itp_pkg::CH_CLOSE);
                depth--;
            end
            if (k != terms - 1)
                text.push_back(random_operator());
        end
        while (depth > 0)
        begin
            text.push_back(itp_pkg::CH_CLOSE);
            depth--;
        end
        send_text(text);
    endtask

    task automatic test_directed();
        send_text('{8'h61, itp_pkg::CH_PLUS, 8'h62, itp_pkg::CH_MUL, 8'h63});
        send_text('{itp_pkg::CH_OPEN, 8'h41, itp_pkg::CH_MINUS, 8'h39,
                    itp_pkg::CH_CLOSE, itp_pkg::CH_DIV, 8'h7A, itp_pkg::CH_POW, 8'h5A});
        // unmatched close, then unmatched open
        send_char(itp_pkg::CH_CLOSE, 1'b1);
        send_char(itp_pkg::CH_OPEN, 1'b1);
        // unknown characters pop the open paren, byte extremes
        send_text('{itp_pkg::CH_OPEN, 8'h23, 8'h30, 8'h00, 8'hFF});
    endtask

    task automatic test_random_expressions();
        for (int n = 0; n < 22; n++)
        begin
            send_expression($urandom_range(1, 6));
            if (n == 11)
                wait_drained();
        end
    endtask

    task automatic test_noise();
        itp_pkg::char_t c;
        for (int n = 0; n < 80; n++)
        begin
            case ($urandom_range(3))
                0, 1: c = 8'($urandom_range(255));
                2:    c = ($urandom_range(1)) ? itp_pkg::CH_OPEN : itp_pkg::CH_CLOSE;
                default: c = random_operator();
            endcase
            send_char(c, $urandom_range(99) < 8);
        end
        send_char(random_operand(), 1'b1);
    endtask

    task automatic test_deep_nesting();
        itp_pkg::char_t text [$];
        // full stack plus dropped pushes, flushed by an operand on the last character
        repeat (STACK_DEPTH + 8)
            text.push_back(itp_pkg::CH_OPEN);
        text.push_back(random_operand());
        send_text(text);
        text.delete();
        repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 6))
        begin
            text.push_back(itp_pkg::CH_OPEN);
            if ($urandom_range(99) < 30)
                text.push_back(random_operator());
        end
        text.push_back(random_operand());
        repeat ($urandom_range(1, 8))
            text.push_back(itp_pkg::CH_CLOSE);
        text.push_back(random_operand());
        send_text(text);
    endtask

    task automatic test_backpressure();
        hold_left = HOLD_CYCLES;
        repeat (4)
            send_expression($urandom_range(3, 6));
        wait_drained();
    endtask

    task automatic test_unbroken_stream();
        quiet = 1'b1;
        repeat (4)
            send_expression($urandom_range(2, 6));
        wait_drained();
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_expressions();
        test_noise();
        test_deep_nesting();
        test_backpressure();
        test_unbroken_stream();
        wait_drained();
        $display("covered %0d characters, %0d postfix transactions, %0d expressions ended",
                 chars_accepted, results_seen, runs_ended);
        $display("stack overflow marked %0d transactions; output hold-off of %0d cycles",
                 flagged_seen, HOLD_CYCLES);
        if (mismatches == 0 && pending_postfix.size() == 0)
            $display("infix_to_postfix_converter_core regression: pass");
        else
            $display("infix_to_postfix_converter_core regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/itp_pkg.sv
sv/itp_ram.sv
sv/infix_to_postfix_converter_core.sv
sv/itp_checker.sv
verif/tb_top.sv
